// ----- rtl/assert_macros.svh -----
// Assertion macros used by the converter's top level.
// Depends on nothing; defining SYNTH turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");
`define ASSERT_NEXT_NR(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset behavior check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT_NR(label, clk, ante, cons)
`endif
`endif

// ----- rtl/rgbyuv_pkg.sv -----
// Types and constants of the blend and color conversion block.
// Used by every module of the block; depends on nothing.
package rgbyuv_pkg;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t REG_ALPHA_FIRST   = 3'd0;
  localparam reg_idx_t REG_ALPHA_SECOND  = 3'd1;
  localparam reg_idx_t REG_LUMA_ROW      = 3'd2;
  localparam reg_idx_t REG_BLUE_DIFF_ROW = 3'd3;
  localparam reg_idx_t REG_RED_DIFF_ROW  = 3'd4;

  localparam int unsigned BLEND_W = 17;
  typedef logic [BLEND_W-1:0] blend_t;

  typedef struct packed {
    blend_t red;
    blend_t green;
    blend_t blue;
    logic   chroma;
  } pix_t;

  typedef struct packed {
    logic signed [15:0] scale_b;
    logic signed [15:0] scale_g;
    logic signed [15:0] scale_r;
    logic signed [15:0] offset;
  } row_cfg_t;

  // The bias is 255 * 8225; it makes the value nonnegative for the division by 255.
  localparam logic [22:0] FLOOR_BIAS = 23'd2097375;
  localparam logic [15:0] BIAS_QUOT  = 16'd8225;
  localparam logic [16:0] RECIP_255  = 17'd65793;
  localparam logic [23:0] DIV_255    = 24'd255;

endpackage

// ----- rtl/rgb_blend_to_yuv420_convert_top.sv -----
// Top level of the alpha blend and RGB to YCbCr 4:2:0 converter.
// Depends on rgbyuv_pkg, rgbyuv_front, rgbyuv_queue, rgbyuv_back, assert_macros.svh.
//
// Each input request carries one pixel of each of two RGB images and the
// parity of its row and column. Each output request carries the clamped Y,
// a chroma flag and Cb and Cr, which read as zero unless the pixel sits on
// an even row and an even column.
// Registers are written through the cfg channel, which is always ready:
// index 0 and 1 are the alpha weights, 2 to 4 the Y, Cb and Cr rows.
// Write them only while no request is in flight.
// An accepted request passes the input register, the queue and the arithmetic
// pipeline. The block takes one request per cycle while the receiver does not
// stall, through the four-stage multiply and divide pipeline that all three rows run in lockstep.
// When the receiver stalls, the result register and the arithmetic freeze,
// the queue between input stage and arithmetic keeps filling, and in_ready
// falls once both the queue and the input register are full.
// Reset empties the pipeline and queue and loads alpha_first with 255,
// alpha_second and all rows with zero.
`include "assert_macros.svh"

module rgb_blend_to_yuv420_convert_top
  import rgbyuv_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red_a,
  input  logic [7:0]  in_green_a,
  input  logic [7:0]  in_blue_a,
  input  logic [7:0]  in_red_b,
  input  logic [7:0]  in_green_b,
  input  logic [7:0]  in_blue_b,
  input  logic        in_row_is_even,
  input  logic        in_column_is_even,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_luma,
  output logic        out_chroma_valid,
  output logic [7:0]  out_blue_diff,
  output logic [7:0]  out_red_diff,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_idx_t    cfg_index,
  input  logic [63:0] cfg_data
);

  logic [7:0] alpha_first_r;
  logic [7:0] alpha_second_r;
  row_cfg_t   luma_row_r;
  row_cfg_t   blue_diff_row_r;
  row_cfg_t   red_diff_row_r;
  logic       push_valid;
  pix_t       push_item;
  logic       push_ready;
  logic       pop_valid;
  pix_t       pop_item;
  logic       pop_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_first_r   <= 8'd255;
      alpha_second_r  <= 8'd0;
      luma_row_r      <= '0;
      blue_diff_row_r <= '0;
      red_diff_row_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALPHA_FIRST:   alpha_first_r   <= cfg_data[7:0];
        REG_ALPHA_SECOND:  alpha_second_r  <= cfg_data[7:0];
        REG_LUMA_ROW:      luma_row_r      <= cfg_data;
        REG_BLUE_DIFF_ROW: blue_diff_row_r <= cfg_data;
        REG_RED_DIFF_ROW:  red_diff_row_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  rgbyuv_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red_a          (in_red_a),
    .in_green_a        (in_green_a),
    .in_blue_a         (in_blue_a),
    .in_red_b          (in_red_b),
    .in_green_b        (in_green_b),
    .in_blue_b         (in_blue_b),
    .in_row_is_even    (in_row_is_even),
    .in_column_is_even (in_column_is_even),
    .alpha_first       (alpha_first_r),
    .alpha_second      (alpha_second_r),
    .push_valid        (push_valid),
    .push_item         (push_item),
    .push_ready        (push_ready)
  );

  rgbyuv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  rgbyuv_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_item         (pop_item),
    .pop_ready        (pop_ready),
    .luma_row         (luma_row_r),
    .blue_diff_row    (blue_diff_row_r),
    .red_diff_row     (red_diff_row_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_luma         (out_luma),
    .out_chroma_valid (out_chroma_valid),
    .out_blue_diff    (out_blue_diff),
    .out_red_diff     (out_red_diff)
  );

  `ASSERT_NEXT_NR(a_reset_empties, clk, !rst_n, !out_valid)
  `ASSERT_IMPLY(a_no_chroma_zero, clk, rst_n, out_valid && !out_chroma_valid, (out_blue_diff == 8'd0) && (out_red_diff == 8'd0))
  `ASSERT_NEXT(a_front_holds, clk, rst_n, push_valid && !push_ready, push_valid)

endmodule

// ----- rtl/rgbyuv_front.sv -----
// Input stage: takes a pixel pair, blends it with the alpha weights and
// classifies it for chroma. Depends on rgbyuv_pkg.
module rgbyuv_front
  import rgbyuv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red_a,
  input  logic [7:0] in_green_a,
  input  logic [7:0] in_blue_a,
  input  logic [7:0] in_red_b,
  input  logic [7:0] in_green_b,
  input  logic [7:0] in_blue_b,
  input  logic       in_row_is_even,
  input  logic       in_column_is_even,
  input  logic [7:0] alpha_first,
  input  logic [7:0] alpha_second,
  output logic       push_valid,
  output pix_t       push_item,
  input  logic       push_ready
);

  logic front_valid_r;
  logic front_valid_nxt;
  pix_t item_r;
  pix_t item_nxt;
  logic in_fire;

  assign in_ready   = !front_valid_r || push_ready;
  assign in_fire    = in_valid && in_ready;
  assign push_valid = front_valid_r;
  assign push_item  = item_r;

  always_comb begin
    front_valid_nxt = in_fire || (front_valid_r && !push_ready);
    item_nxt.red    = BLEND_W'(in_red_a * alpha_first) + BLEND_W'(in_red_b * alpha_second);
    item_nxt.green  = BLEND_W'(in_green_a * alpha_first) + BLEND_W'(in_green_b * alpha_second);
    item_nxt.blue   = BLEND_W'(in_blue_a * alpha_first) + BLEND_W'(in_blue_b * alpha_second);
    item_nxt.chroma = in_row_is_even && in_column_is_even;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ----- rtl/rgbyuv_queue.sv -----
// Short first-in first-out queue between the input stage and the arithmetic.
// Depends on rgbyuv_pkg.
module rgbyuv_queue
  import rgbyuv_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  pix_t push_item,
  output logic push_ready,
  output logic pop_valid,
  output pix_t pop_item,
  input  logic pop_ready
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pix_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/rgbyuv_row.sv -----
// One matrix row in four stages: products, sum and scaling, division by 255,
// offset and clamp. Depends on rgbyuv_pkg.
module rgbyuv_row
  import rgbyuv_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  blend_t     m_red,
  input  blend_t     m_green,
  input  blend_t     m_blue,
  input  row_cfg_t   row_cfg,
  output logic [7:0] val_r
);

  logic signed [33:0] p_red_r;
  logic signed [33:0] p_green_r;
  logic signed [33:0] p_blue_r;
  logic signed [33:0] p_red_nxt;
  logic signed [33:0] p_green_nxt;
  logic signed [33:0] p_blue_nxt;
  logic signed [35:0] sum;
  logic [21:0]        scaled;
  logic [22:0]        biased_r;
  logic [22:0]        biased_nxt;
  logic [22:0]        biased_d_r;
  logic [39:0]        prod;
  logic [15:0]        quot_est_r;
  logic [23:0]        quot_x255;
  logic [23:0]        rem;
  logic [15:0]        quot;
  logic signed [17:0] sum_off;
  logic [7:0]         val_nxt;

  always_comb begin
    p_red_nxt   = row_cfg.scale_r * $signed({1'b0, m_red});
    p_green_nxt = row_cfg.scale_g * $signed({1'b0, m_green});
    p_blue_nxt  = row_cfg.scale_b * $signed({1'b0, m_blue});
    sum         = 36'(p_red_r) + 36'(p_green_r) + 36'(p_blue_r);
    scaled      = sum[35:14];
    biased_nxt  = {scaled[21], scaled} + FLOOR_BIAS;
    prod        = {17'b0, biased_r} * {23'b0, RECIP_255};
    quot_x255   = {quot_est_r, 8'b0} - {8'b0, quot_est_r};
    rem         = {1'b0, biased_d_r} - quot_x255;
    quot        = quot_est_r + {15'b0, (rem >= DIV_255)};
    sum_off     = $signed({{2{row_cfg.offset[15]}}, row_cfg.offset})
                + $signed({2'b0, quot}) - $signed({2'b0, BIAS_QUOT});
    if (sum_off[17]) begin
      val_nxt = 8'd0;
    end else if (sum_off[16:8] != 9'd0) begin
      val_nxt = 8'd255;
    end else begin
      val_nxt = sum_off[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_red_r    <= p_red_nxt;
      p_green_r  <= p_green_nxt;
      p_blue_r   <= p_blue_nxt;
      biased_r   <= biased_nxt;
      quot_est_r <= prod[39:24];
      biased_d_r <= biased_r;
      val_r      <= val_nxt;
    end
  end

endmodule

// ----- rtl/rgbyuv_back.sv -----
// Arithmetic back end: three matrix rows in lockstep and the result register.
// Depends on rgbyuv_pkg and rgbyuv_row.
module rgbyuv_back
  import rgbyuv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  input  pix_t       pop_item,
  output logic       pop_ready,
  input  row_cfg_t   luma_row,
  input  row_cfg_t   blue_diff_row,
  input  row_cfg_t   red_diff_row,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_luma,
  output logic       out_chroma_valid,
  output logic [7:0] out_blue_diff,
  output logic [7:0] out_red_diff
);

  localparam int unsigned STAGES = 4;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] valid_nxt;
  logic [STAGES-1:0] chroma_r;
  logic              en;
  logic [7:0]        luma_val;
  logic [7:0]        blue_val;
  logic [7:0]        red_val;

  assign en        = !valid_r[STAGES-1] || out_ready;
  assign pop_ready = en;
  assign valid_nxt = en ? {valid_r[STAGES-2:0], pop_valid} : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chroma_r <= {chroma_r[STAGES-2:0], pop_item.chroma};
    end
  end

  rgbyuv_row u_luma (
    .clk     (clk),
    .en      (en),
    .m_red   (pop_item.red),
    .m_green (pop_item.green),
    .m_blue  (pop_item.blue),
    .row_cfg (luma_row),
    .val_r   (luma_val)
  );

  rgbyuv_row u_blue_diff (
    .clk     (clk),
    .en      (en),
    .m_red   (pop_item.red),
    .m_green (pop_item.green),
    .m_blue  (pop_item.blue),
    .row_cfg (blue_diff_row),
    .val_r   (blue_val)
  );

  rgbyuv_row u_red_diff (
    .clk     (clk),
    .en      (en),
    .m_red   (pop_item.red),
    .m_green (pop_item.green),
    .m_blue  (pop_item.blue),
    .row_cfg (red_diff_row),
    .val_r   (red_val)
  );

  assign out_valid        = valid_r[STAGES-1];
  assign out_luma         = luma_val;
  assign out_chroma_valid = chroma_r[STAGES-1];
  assign out_blue_diff    = chroma_r[STAGES-1] ? blue_val : 8'd0;
  assign out_red_diff     = chroma_r[STAGES-1] ? red_val : 8'd0;

endmodule
